// ----- src/wsb_pkg.sv -----
// Shared types and constants for the waypoint steering block.
package wsb_pkg;

  localparam logic [1:0] REQ_ODOM    = 2'd0;
  localparam logic [1:0] REQ_ADVANCE = 2'd1;
  localparam logic [1:0] REQ_START   = 2'd2;

  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_DRIVE    = 3'd1;
  localparam logic [2:0] ACT_STOP     = 3'd2;
  localparam logic [2:0] ACT_WALL     = 3'd3;
  localparam logic [2:0] ACT_DONE     = 3'd4;
  localparam logic [2:0] ACT_EMPTY    = 3'd5;
  localparam logic [2:0] ACT_OVERFLOW = 3'd6;

  localparam logic [0:0] ADDR_THRESHOLD = 1'd0;
  localparam logic [0:0] ADDR_SPEED     = 1'd1;

  // Steering request to the arithmetic unit and its answer.
  typedef struct packed {
    logic               start;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic [15:0]        speed;
  } steer_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
  } steer_rsp_t;

endpackage

// ----- src/wsb_steer.sv -----
// Iterative square root and two restoring divisions that compute the velocity.
module wsb_steer (
  input  logic                clk,
  input  logic                rst,
  input  wsb_pkg::steer_req_t req,
  output wsb_pkg::steer_rsp_t rsp
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SQ   = 5'b00010,
    S_SQRT = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t      state;
  logic [17:0] ax;
  logic [17:0] ay;
  logic        nx;
  logic        ny;
  logic [15:0] speed;
  logic [36:0] rem;
  logic [36:0] root;
  logic [36:0] bit_m;
  logic [5:0]  cnt;
  logic [33:0] numx;
  logic [33:0] numy;
  logic [33:0] qx;
  logic [33:0] qy;
  logic [34:0] rx;
  logic [34:0] ry;
  logic [36:0] sq;
  logic [34:0] rx_sh;
  logic [34:0] ry_sh;
  logic [15:0] satx;
  logic [15:0] saty;

  assign rx_sh = {rx[33:0], numx[33]};
  assign ry_sh = {ry[33:0], numy[33]};

  always_comb begin
    if (nx) begin
      satx = (qx > 34'd32768) ? 16'h8000 : 16'(-qx);
    end else begin
      satx = (qx > 34'd32767) ? 16'h7fff : qx[15:0];
    end
    if (ny) begin
      saty = (qy > 34'd32768) ? 16'h8000 : 16'(-qy);
    end else begin
      saty = (qy > 34'd32767) ? 16'h7fff : qy[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.start) begin
            nx    <= req.dx[17];
            ny    <= req.dy[17];
            ax    <= req.dx[17] ? 18'(-req.dx) : req.dx;
            ay    <= req.dy[17] ? 18'(-req.dy) : req.dy;
            speed <= req.speed;
            cnt   <= 6'd0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt == 6'd0) begin
            sq  <= 37'(ax * ax);
            cnt <= 6'd1;
          end else begin
            rem   <= sq + 37'(ay * ay);
            root  <= 37'd0;
            bit_m <= 37'd1 << 36;
            numx  <= 34'(ax * speed);
            cnt   <= 6'd0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (cnt == 6'd0) begin
            numy <= 34'(ay * speed);
            cnt  <= 6'd1;
          end
          if (rem >= root + bit_m) begin
            rem  <= rem - (root + bit_m);
            root <= (root >> 1) + bit_m;
          end else begin
            root <= root >> 1;
          end
          bit_m <= bit_m >> 2;
          if (bit_m[0]) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (root == 37'd0) begin
            qx    <= 34'd0;
            qy    <= 34'd0;
            state <= S_OUT;
          end else begin
            // Add half the divisor once, then divide bit by bit.
            if (cnt == 6'd1) begin
              numx <= numx + 34'(root >> 1);
              numy <= numy + 34'(root >> 1);
              rx   <= 35'd0;
              ry   <= 35'd0;
              cnt  <= 6'd35;
            end else begin
              numx <= numx << 1;
              numy <= numy << 1;
              if (rx_sh >= 35'(root)) begin
                rx <= rx_sh - 35'(root);
                qx <= {qx[32:0], 1'b1};
              end else begin
                rx <= rx_sh;
                qx <= {qx[32:0], 1'b0};
              end
              if (ry_sh >= 35'(root)) begin
                ry <= ry_sh - 35'(root);
                qy <= {qy[32:0], 1'b1};
              end else begin
                ry <= ry_sh;
                qy <= {qy[32:0], 1'b0};
              end
              cnt <= cnt - 6'd1;
              if (cnt == 6'd2) begin
                state <= S_OUT;
              end
            end
          end
        end
        S_OUT: begin
          rsp.vx   <= satx;
          rsp.vy   <= saty;
          rsp.done <= 1'b1;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/waypoint_steer_with_backtrack.sv -----
// Top level: request sequencer, goal stack memory and configuration port.
// Each request takes one result. A start request, or any request that neither
// evaluates nor drives, goes straight to the output state; an odometry request
// first passes the evaluation state, and a request that drives waits for the
// steering unit, whose run is set by the bit-serial square root (19 steps)
// and the shared two-lane divider (34 steps). The goal stack is a synchronous
// memory of STACK_DEPTH entries whose read data comes in the cycle after its
// address; a new request is taken once the previous result has left the
// output register, so a stalled output delays the next acceptance.
module waypoint_steer_with_backtrack #(
  parameter int STACK_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               ready,
  input  logic [1:0]         req_type,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic               all_explored,
  input  logic               next_valid,
  input  logic               next_free,
  input  logic signed [7:0]  next_row,
  input  logic signed [7:0]  next_col,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         action,
  output logic signed [15:0] vel_x,
  output logic signed [15:0] vel_y,
  output logic signed [7:0]  target_row,
  output logic signed [7:0]  target_col,
  output logic               is_stopped,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EVAL  = 5'b00010,
    S_POP   = 5'b00100,
    S_STEER = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t             state;
  logic [15:0]        reach_threshold;
  logic [15:0]        drive_speed;
  logic signed [7:0]  goal_row;
  logic signed [7:0]  goal_col;
  logic signed [15:0] last_pos_x;
  logic signed [15:0] last_pos_y;
  logic               stop_latch;
  logic               finished_latch;
  logic [LW-1:0]      stack_level;
  logic [15:0]        goal_stack [STACK_DEPTH];
  logic [15:0]        rd_data;
  logic [AW-1:0]      rd_addr;
  logic [2:0]         act;
  logic               wall;
  logic signed [7:0]  wall_row;
  logic signed [7:0]  wall_col;
  logic signed [17:0] dx;
  logic signed [17:0] dy;
  logic [36:0]        d2;
  logic [31:0]        thr2;
  logic               steer_start;
  wsb_pkg::steer_req_t sreq;
  wsb_pkg::steer_rsp_t srsp;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign ready  = (state == S_IDLE) && !out_valid;
  assign rd_addr = AW'(stack_level - LW'(1));

  always_comb begin
    case (paddr[2])
      wsb_pkg::ADDR_THRESHOLD: prdata = {16'd0, reach_threshold};
      default:                 prdata = {16'd0, drive_speed};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reach_threshold <= 16'd51;
      drive_speed     <= 16'd256;
    end else if (cfg_wr) begin
      case (paddr[2])
        wsb_pkg::ADDR_THRESHOLD: reach_threshold <= pwdata[15:0];
        wsb_pkg::ADDR_SPEED:     drive_speed     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= goal_stack[rd_addr];
    if (valid && ready && req_type == wsb_pkg::REQ_ADVANCE && stop_latch && !finished_latch
        && !all_explored && next_valid && next_free && stack_level < LW'(STACK_DEPTH)) begin
      goal_stack[stack_level[AW-1:0]] <= {goal_row, goal_col};
    end
  end

  assign dx = 18'(goal_row) * 18'sd256 - 18'(last_pos_x);
  assign dy = 18'(goal_col) * 18'sd256 - 18'(last_pos_y);

  always_ff @(posedge clk) begin
    d2   <= 37'(dx * dx) + 37'(dy * dy);
    thr2 <= reach_threshold * reach_threshold;
  end

  assign sreq.start = steer_start;
  assign sreq.dx    = dx;
  assign sreq.dy    = dy;
  assign sreq.speed = drive_speed;

  wsb_steer u_steer (
    .clk (clk),
    .rst (rst),
    .req (sreq),
    .rsp (srsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      goal_row       <= '0;
      goal_col       <= '0;
      last_pos_x     <= '0;
      last_pos_y     <= '0;
      stop_latch     <= 1'b0;
      finished_latch <= 1'b0;
      stack_level    <= '0;
      out_valid      <= 1'b0;
      steer_start    <= 1'b0;
    end else begin
      steer_start <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (valid && ready) begin
            act  <= wsb_pkg::ACT_NONE;
            wall <= 1'b0;
            wall_row <= next_row;
            wall_col <= next_col;
            state <= S_OUT;
            case (req_type)
              wsb_pkg::REQ_START: begin
                goal_row       <= next_row;
                goal_col       <= next_col;
                stack_level    <= '0;
                stop_latch     <= 1'b0;
                finished_latch <= 1'b0;
              end
              wsb_pkg::REQ_ODOM: begin
                if (!stop_latch && !finished_latch) begin
                  last_pos_x <= pos_x;
                  last_pos_y <= pos_y;
                  state      <= S_EVAL;
                end
              end
              wsb_pkg::REQ_ADVANCE: begin
                if (stop_latch && !finished_latch) begin
                  if (all_explored) begin
                    finished_latch <= 1'b1;
                    act <= wsb_pkg::ACT_DONE;
                  end else if (next_valid) begin
                    if (!next_free) begin
                      wall <= 1'b1;
                      act  <= wsb_pkg::ACT_WALL;
                    end else if (stack_level >= LW'(STACK_DEPTH)) begin
                      act <= wsb_pkg::ACT_OVERFLOW;
                    end else begin
                      stack_level <= stack_level + LW'(1);
                      goal_row    <= next_row;
                      goal_col    <= next_col;
                      stop_latch  <= 1'b0;
                      act         <= wsb_pkg::ACT_DRIVE;
                      steer_start <= 1'b1;
                      state       <= S_STEER;
                    end
                  end else if (stack_level != '0) begin
                    stack_level <= stack_level - LW'(1);
                    stop_latch  <= 1'b0;
                    act         <= wsb_pkg::ACT_DRIVE;
                    state       <= S_POP;
                  end else begin
                    finished_latch <= 1'b1;
                    act <= wsb_pkg::ACT_EMPTY;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_EVAL: begin
          // Wait for the registered squares: the first pass only sets the action to drive.
          if (act == wsb_pkg::ACT_NONE) begin
            act <= wsb_pkg::ACT_DRIVE;
          end else if (d2 < 37'(thr2)) begin
            stop_latch <= 1'b1;
            act   <= wsb_pkg::ACT_STOP;
            state <= S_OUT;
          end else begin
            steer_start <= 1'b1;
            state <= S_STEER;
          end
        end
        S_POP: begin
          goal_row    <= rd_data[15:8];
          goal_col    <= rd_data[7:0];
          steer_start <= 1'b1;
          state       <= S_STEER;
        end
        S_STEER: begin
          if (srsp.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid  <= 1'b1;
          action     <= act;
          vel_x      <= (act == wsb_pkg::ACT_DRIVE) ? srsp.vx : 16'sd0;
          vel_y      <= (act == wsb_pkg::ACT_DRIVE) ? srsp.vy : 16'sd0;
          target_row <= wall ? wall_row : goal_row;
          target_col <= wall ? wall_col : goal_col;
          is_stopped <= stop_latch;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    stack_level <= LW'(STACK_DEPTH)) else $error("stack level beyond depth");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !ready) else $error("request taken while busy");
  a_drive_moving: assert property (@(posedge clk) disable iff (rst)
    (out_valid && action == wsb_pkg::ACT_DRIVE) |-> !is_stopped)
    else $error("drive result while stopped");
`endif

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the waypoint steering block with goal backtracking.
module tb;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic               explored;
    logic               offered;
    logic               clear;
    logic signed [7:0]  row;
    logic signed [7:0]  col;
  } request_t;

  typedef struct packed {
    logic [2:0]         act;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [7:0]  trow;
    logic signed [7:0]  tcol;
    logic               stopped;
  } steer_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid = 1'b0;
  logic ready;
  logic [1:0] req_type = wsb_pkg::REQ_ODOM;
  logic signed [15:0] pos_x = '0, pos_y = '0;
  logic all_explored = 1'b0, next_valid = 1'b0, next_free = 1'b0;
  logic signed [7:0] next_row = '0, next_col = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] action;
  logic signed [15:0] vel_x, vel_y;
  logic signed [7:0] target_row, target_col;
  logic is_stopped;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  waypoint_steer_with_backtrack uut (.*);

  always #5 clk = ~clk;

  // Predictor state.
  logic [15:0] thr_q, speed_q;
  logic signed [7:0] goal_r, goal_c;
  logic signed [15:0] seen_x, seen_y;
  logic halted, done_flag;
  logic [15:0] goal_store [256];
  int unsigned depth_q;

  request_t pending_requests[$];
  steer_out_t expected_results[$];
  int mismatches = 0;
  int burst_left = 0, gap_left = 0;
  int stall_phase = 0;

  function automatic logic [63:0] root_floor(logic [63:0] n);
    logic [63:0] r, bit_q;
    r = 0;
    bit_q = 64'd1 << 62;
    while (bit_q > n) bit_q = bit_q >> 2;
    while (bit_q != 0) begin
      if (n >= r + bit_q) begin
        n = n - (r + bit_q);
        r = (r >> 1) + bit_q;
      end else begin
        r = r >> 1;
      end
      bit_q = bit_q >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] axis_speed(longint diff, logic [63:0] norm);
    logic [63:0] mag, q;
    if (norm == 0) return 16'sd0;
    mag = (diff < 0 ? -diff : diff) * speed_q;
    q = (mag + norm / 2) / norm;
    if (diff < 0) return q > 32768 ? 16'sh8000 : 16'(-longint'(q));
    return q > 32767 ? 16'sd32767 : 16'(q);
  endfunction

  task automatic head_for_goal(output logic signed [15:0] vx, output logic signed [15:0] vy);
    longint dx, dy;
    logic [63:0] norm;
    dx = longint'(goal_r) * 256 - longint'(seen_x);
    dy = longint'(goal_c) * 256 - longint'(seen_y);
    norm = root_floor(dx * dx + dy * dy);
    vx = axis_speed(dx, norm);
    vy = axis_speed(dy, norm);
  endtask

  task automatic predict_steer(request_t r);
    steer_out_t e;
    logic wall;
    longint dx, dy;
    e = '0;
    e.act = wsb_pkg::ACT_NONE;
    wall = 1'b0;
    if (r.kind == wsb_pkg::REQ_START) begin
      goal_r = r.row; goal_c = r.col; depth_q = 0; halted = 1'b0; done_flag = 1'b0;
    end else if (r.kind == wsb_pkg::REQ_ODOM) begin
      if (!halted && !done_flag) begin
        seen_x = r.px; seen_y = r.py;
        dx = longint'(goal_r) * 256 - longint'(seen_x);
        dy = longint'(goal_c) * 256 - longint'(seen_y);
        if (dx * dx + dy * dy < longint'(thr_q) * longint'(thr_q)) begin
          halted = 1'b1; e.act = wsb_pkg::ACT_STOP;
        end else begin
          head_for_goal(e.vx, e.vy); e.act = wsb_pkg::ACT_DRIVE;
        end
      end
    end else if (r.kind == wsb_pkg::REQ_ADVANCE) begin
      if (halted && !done_flag) begin
        if (r.explored) begin
          done_flag = 1'b1; e.act = wsb_pkg::ACT_DONE;
        end else if (r.offered) begin
          if (!r.clear) begin
            wall = 1'b1; e.act = wsb_pkg::ACT_WALL;
          end else if (depth_q >= 256) begin
            e.act = wsb_pkg::ACT_OVERFLOW;
          end else begin
            goal_store[8'(depth_q)] = {goal_r, goal_c};
            depth_q++;
            goal_r = r.row; goal_c = r.col; halted = 1'b0;
            head_for_goal(e.vx, e.vy); e.act = wsb_pkg::ACT_DRIVE;
          end
        end else if (depth_q > 0) begin
          depth_q--;
          {goal_r, goal_c} = goal_store[8'(depth_q)];
          halted = 1'b0;
          head_for_goal(e.vx, e.vy); e.act = wsb_pkg::ACT_DRIVE;
        end else begin
          done_flag = 1'b1; e.act = wsb_pkg::ACT_EMPTY;
        end
      end
    end
    e.trow = wall ? r.row : goal_r;
    e.tcol = wall ? r.col : goal_c;
    e.stopped = halted;
    expected_results.push_back(e);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // Driver: bursts and gaps; valid stays high until acceptance.
  always @(posedge clk) begin
    if (!rst) begin
      if (valid && ready) predict_steer(pending_requests.pop_front());
      if (!valid || ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          request_t n;
          n = pending_requests[0];
          valid <= 1'b1;
          req_type <= n.kind; pos_x <= n.px; pos_y <= n.py;
          all_explored <= n.explored; next_valid <= n.offered; next_free <= n.clear;
          next_row <= n.row; next_col <= n.col;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall pattern.
  always @(posedge clk) begin
    if (!rst) begin
      stall_phase <= (stall_phase + 1) % 97;
      out_ready <= stall_phase < 40 ? 1'b1 : ($urandom_range(0, 2) != 0);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", action, -1);
        end else begin
          steer_out_t e;
          e = expected_results.pop_front();
          if (action !== e.act) report_mismatch("action", action, e.act);
          if (vel_x !== e.vx) report_mismatch("vel_x", vel_x, e.vx);
          if (vel_y !== e.vy) report_mismatch("vel_y", vel_y, e.vy);
          if (target_row !== e.trow) report_mismatch("target_row", target_row, e.trow);
          if (target_col !== e.tcol) report_mismatch("target_col", target_col, e.tcol);
          if (is_stopped !== e.stopped) report_mismatch("is_stopped", is_stopped, e.stopped);
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] addr, logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == {wsb_pkg::ADDR_THRESHOLD, 2'b00}) thr_q = value; else speed_q = value;
  endtask

  task automatic settle;
    while (pending_requests.size() != 0 || valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic request_t make_req(logic [1:0] k, int x, int y, int a, int v,
                                        int f, int r, int c);
    request_t q;
    q.kind = k; q.px = 16'(x); q.py = 16'(y);
    q.explored = 1'(a); q.offered = 1'(v); q.clear = 1'(f);
    q.row = 8'(r); q.col = 8'(c);
    return q;
  endfunction

  function automatic request_t random_req();
    request_t q;
    int pick;
    q = make_req(2'($urandom_range(0, 3)), int'($urandom), int'($urandom), int'($urandom),
                 int'($urandom), int'($urandom), int'($urandom), int'($urandom));
    pick = $urandom_range(0, 99);
    // Mostly a well-formed walk: arrive, push or pop, move on.
    if (pick < 35) begin
      q.kind = wsb_pkg::REQ_ODOM;
      q.px = 16'(goal_r * 256 + $signed($urandom_range(0, 60)) - 30);
      q.py = 16'(goal_c * 256 + $signed($urandom_range(0, 60)) - 30);
    end else if (pick < 70) begin
      q.kind = wsb_pkg::REQ_ADVANCE;
      q.explored = $urandom_range(0, 15) == 0;
      q.offered = $urandom_range(0, 2) != 0;
      q.clear = $urandom_range(0, 4) != 0;
    end else if (pick < 75) begin
      q.kind = wsb_pkg::REQ_START;
    end
    return q;
  endfunction

  // The predictor tracks the goal only when items are accepted, so random
  // generation uses a rough shadow of it to keep odometry near the goal.
  initial begin
    thr_q = 16'd51; speed_q = 16'd256;
    goal_r = '0; goal_c = '0; seen_x = '0; seen_y = '0;
    halted = 1'b0; done_flag = 1'b0; depth_q = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    pending_requests.push_back(make_req(wsb_pkg::REQ_ODOM, 0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(wsb_pkg::REQ_ADVANCE, 0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(wsb_pkg::REQ_START, 0, 0, 0, 0, 0, 127, -128));
    pending_requests.push_back(make_req(wsb_pkg::REQ_ODOM, -32768, 32767, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(wsb_pkg::REQ_ODOM, 32767, -32768, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(wsb_pkg::REQ_ODOM, 32512, -32768, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(wsb_pkg::REQ_ADVANCE, 0, 0, 0, 1, 0, 5, 5));
    pending_requests.push_back(make_req(wsb_pkg::REQ_ADVANCE, 0, 0, 0, 1, 1, -128, 127));
    pending_requests.push_back(make_req(wsb_pkg::REQ_ADVANCE, 0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(wsb_pkg::REQ_ODOM, -32768, 32767, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(wsb_pkg::REQ_ADVANCE, 0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(wsb_pkg::REQ_ODOM, 32512, -32768, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(wsb_pkg::REQ_ADVANCE, 0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(wsb_pkg::REQ_ODOM, 0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(wsb_pkg::REQ_START, 0, 0, 0, 0, 0, 1, 1));
    pending_requests.push_back(make_req(wsb_pkg::REQ_ODOM, 256, 256, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(wsb_pkg::REQ_ADVANCE, 0, 0, 1, 1, 1, 0, 0));
    pending_requests.push_back(make_req(wsb_pkg::REQ_ODOM, 0, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(2'd3, 0, 0, 1, 1, 1, -1, -1));
    settle();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg({wsb_pkg::ADDR_THRESHOLD, 2'b00}, 16'd51);
          write_reg({wsb_pkg::ADDR_SPEED, 2'b00}, 16'd256);
        end
        1: begin
          write_reg({wsb_pkg::ADDR_THRESHOLD, 2'b00}, 16'd0);
          write_reg({wsb_pkg::ADDR_SPEED, 2'b00}, 16'hffff);
        end
        2: begin
          write_reg({wsb_pkg::ADDR_THRESHOLD, 2'b00}, 16'd40);
          write_reg({wsb_pkg::ADDR_SPEED, 2'b00}, 16'd0);
        end
        3: begin
          write_reg({wsb_pkg::ADDR_THRESHOLD, 2'b00}, 16'($urandom));
          write_reg({wsb_pkg::ADDR_SPEED, 2'b00}, 16'($urandom));
        end
        default: begin
          write_reg({wsb_pkg::ADDR_THRESHOLD, 2'b00}, 16'd30);
          write_reg({wsb_pkg::ADDR_SPEED, 2'b00}, 16'd700);
        end
      endcase
      for (int i = 0; i < 86; i++) begin
        pending_requests.push_back(random_req());
        // Let the shadow goal catch up now and then so odometry lands nearby.
        if (i % 8 == 7) while (pending_requests.size() != 0) @(posedge clk);
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- waypoint_steer_with_backtrack.f -----
src/wsb_pkg.sv
src/wsb_steer.sv
src/waypoint_steer_with_backtrack.sv
test/tb.sv
